FILE: rtl/tscan_pkg.sv
// shared types, token codes and keyword tables of the token scanner
`default_nettype none

package tscan_pkg;

	localparam int KW_COUNT       = 11;
	localparam int KW_TEXT_LEN    = 9;
	localparam int FIFO_DEPTH_DEF = 4;

	// token kinds
	localparam logic [5:0] KIND_EOF       = 6'd0;
	localparam logic [5:0] KIND_UNKNOWN   = 6'd1;
	localparam logic [5:0] KIND_KW_FIRST  = 6'd2;
	localparam logic [5:0] KIND_PERIOD    = 6'd13;
	localparam logic [5:0] KIND_COMMA     = 6'd14;
	localparam logic [5:0] KIND_SEMI      = 6'd15;
	localparam logic [5:0] KIND_ASSIGN    = 6'd16;
	localparam logic [5:0] KIND_QUERY     = 6'd17;
	localparam logic [5:0] KIND_BANG      = 6'd18;
	localparam logic [5:0] KIND_EQUAL     = 6'd19;
	localparam logic [5:0] KIND_HASH      = 6'd20;
	localparam logic [5:0] KIND_LESS      = 6'd21;
	localparam logic [5:0] KIND_LESSEQ    = 6'd22;
	localparam logic [5:0] KIND_GREATER   = 6'd23;
	localparam logic [5:0] KIND_GREATEREQ = 6'd24;
	localparam logic [5:0] KIND_PLUS      = 6'd25;
	localparam logic [5:0] KIND_MINUS     = 6'd26;
	localparam logic [5:0] KIND_STAR      = 6'd27;
	localparam logic [5:0] KIND_SLASH     = 6'd28;
	localparam logic [5:0] KIND_LPAREN    = 6'd29;
	localparam logic [5:0] KIND_RPAREN    = 6'd30;
	localparam logic [5:0] KIND_NUMBER    = 6'd31;
	localparam logic [5:0] KIND_IDENT     = 6'd32;

	localparam logic [23:0] LINE_MAX  = '1;
	localparam logic [15:0] COUNT_MAX = '1;
	localparam logic [62:0] NUM_MAX   = '1;

	typedef logic [KW_COUNT-1:0] kw_mask_t;
	localparam kw_mask_t KW_ALL = '1;

	// keyword text, left aligned, zero padded
	typedef logic [0:KW_TEXT_LEN-1][7:0] kw_text_t;
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		{"const", 32'h0}, {"var", 48'h0}, {"procedure"}, {"call", 40'h0},
		{"begin", 32'h0}, {"end", 48'h0}, {"if", 56'h0}, {"then", 40'h0},
		{"while", 32'h0}, {"do", 56'h0}, {"odd", 48'h0}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
	};

	// pending token class
	typedef enum logic [5:0] {
		P_NONE    = 6'b000001,
		P_WORD    = 6'b000010,
		P_NUM     = 6'b000100,
		P_COLON   = 6'b001000,
		P_LESS    = 6'b010000,
		P_GREATER = 6'b100000
	} pend_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [23:0] token_line;
		logic [15:0] token_column;
		logic [15:0] token_length;
		logic [62:0] number_value;
		logic        number_overflow;
		logic [7:0]  odd_byte;
		logic        run_last;
	} token_t;

	// results of one byte, handed to the result queue
	typedef struct packed {
		logic [1:0] cnt;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// keep the keywords whose character at pos matches c
	function automatic kw_mask_t kw_filter(input kw_mask_t mask, input logic [15:0] pos,
			input logic [7:0] c);
		logic [7:0] lc;
		kw_mask_t   res;
		lc  = to_lower(c);
		res = '0;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (mask[i] && pos < {12'd0, KW_LEN[i]}) begin
				if (lc == KW_TEXT[i][pos[3:0]])
					res[i] = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic [5:0] kw_kind(input kw_mask_t mask, input logic [15:0] len);
		logic [5:0] kind;
		kind = KIND_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (mask[i] && len == {12'd0, KW_LEN[i]})
				kind = KIND_KW_FIRST + 6'(i);
		end
		return kind;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] kind;
		case (c)
			".":     kind = KIND_PERIOD;
			",":     kind = KIND_COMMA;
			";":     kind = KIND_SEMI;
			"?":     kind = KIND_QUERY;
			"!":     kind = KIND_BANG;
			"=":     kind = KIND_EQUAL;
			"#":     kind = KIND_HASH;
			"+":     kind = KIND_PLUS;
			"-":     kind = KIND_MINUS;
			"*":     kind = KIND_STAR;
			"/":     kind = KIND_SLASH;
			"(":     kind = KIND_LPAREN;
			")":     kind = KIND_RPAREN;
			default: kind = KIND_UNKNOWN;
		endcase
		return kind;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tscan_ifs.sv
// valid/ready channels for source bytes and tokens
`default_nettype none

interface tscan_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source(output valid, output source_byte, input ready);
	modport sink(input valid, input source_byte, output ready);
endinterface

interface tscan_token_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [23:0] token_line;
	logic [15:0] token_column;
	logic [15:0] token_length;
	logic [62:0] number_value;
	logic        number_overflow;
	logic [7:0]  odd_byte;
	logic        run_last;

	modport source(output valid, output token_kind, output token_line, output token_column,
		output token_length, output number_value, output number_overflow,
		output odd_byte, output run_last, input ready);
	modport sink(input valid, input token_kind, input token_line, input token_column,
		input token_length, input number_value, input number_overflow,
		input odd_byte, input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tscan_core.sv
// scanner state and per-byte token decision
`default_nettype none

module tscan_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        src_byte,
	output tscan_pkg::push_t       push,
	output logic                   ended
);

	tscan_pkg::pend_t    pend_q, pend_d;
	tscan_pkg::kw_mask_t kw_q, kw_d;
	logic [62:0]         acc_q, acc_d;
	logic                ovf_q, ovf_d;
	logic [15:0]         plen_q, plen_d;
	logic [23:0]         line_q, line_d;
	logic [15:0]         col_q, col_d;
	logic [15:0]         start_q, start_d;
	logic                ended_q, ended_d;

	logic                alpha, digit, blank;
	logic [15:0]         col_inc;
	logic [66:0]         acc_wide;
	logic                has_flush, has_new;
	tscan_pkg::token_t   flush_tok, new_tok, first, second;
	logic [1:0]          cnt;

	always_comb begin
		alpha    = (src_byte >= "A" && src_byte <= "Z") ||
		           (src_byte >= "a" && src_byte <= "z") || src_byte == "_";
		digit    = src_byte >= "0" && src_byte <= "9";
		blank    = src_byte == 8'h20 || src_byte == 8'h09 || src_byte == 8'h0D ||
		           src_byte == 8'h0C || src_byte == 8'h0B;
		col_inc  = tscan_pkg::sat16(col_q);
		// times ten plus digit, no multiplier
		acc_wide = 67'({acc_q, 3'b000}) + 67'({acc_q, 1'b0}) + 67'(src_byte[3:0]);

		pend_d  = pend_q;
		kw_d    = kw_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		plen_d  = plen_q;
		line_d  = line_q;
		col_d   = col_q;
		start_d = start_q;
		ended_d = ended_q;

		// token for whatever is pending
		flush_tok              = '0;
		flush_tok.token_line   = line_q;
		flush_tok.token_column = start_q;
		flush_tok.token_length = 16'd1;
		has_flush              = 1'b1;
		case (pend_q)
			tscan_pkg::P_WORD: begin
				flush_tok.token_kind   = tscan_pkg::kw_kind(kw_q, plen_q);
				flush_tok.token_length = plen_q;
			end
			tscan_pkg::P_NUM: begin
				flush_tok.token_kind      = tscan_pkg::KIND_NUMBER;
				flush_tok.token_length    = plen_q;
				flush_tok.number_value    = acc_q;
				flush_tok.number_overflow = ovf_q;
			end
			tscan_pkg::P_COLON: begin
				flush_tok.token_kind = tscan_pkg::KIND_UNKNOWN;
				flush_tok.odd_byte   = ":";
			end
			tscan_pkg::P_LESS:    flush_tok.token_kind = tscan_pkg::KIND_LESS;
			tscan_pkg::P_GREATER: flush_tok.token_kind = tscan_pkg::KIND_GREATER;
			default:              has_flush = 1'b0;
		endcase

		new_tok              = '0;
		new_tok.token_line   = line_q;
		new_tok.token_column = col_q;
		has_new              = 1'b0;

		first  = '0;
		second = '0;
		cnt    = 2'd0;

		if (ended_q) begin
			// eof answered for every byte after the end
			first = new_tok;
			cnt   = 2'd1;
		end else if (pend_q == tscan_pkg::P_WORD && (alpha || digit)) begin
			kw_d   = tscan_pkg::kw_filter(kw_q, plen_q, src_byte);
			plen_d = tscan_pkg::sat16(plen_q);
			col_d  = col_inc;
		end else if (pend_q == tscan_pkg::P_NUM && digit) begin
			if (!ovf_q && acc_wide[66:63] == 4'd0) begin
				acc_d = acc_wide[62:0];
			end else begin
				ovf_d = 1'b1;
				acc_d = tscan_pkg::NUM_MAX;
			end
			plen_d = tscan_pkg::sat16(plen_q);
			col_d  = col_inc;
		end else if ((pend_q == tscan_pkg::P_COLON || pend_q == tscan_pkg::P_LESS ||
		              pend_q == tscan_pkg::P_GREATER) && src_byte == "=") begin
			first              = flush_tok;
			first.token_length = 16'd2;
			first.odd_byte     = 8'd0;
			first.token_kind   = (pend_q == tscan_pkg::P_COLON) ? tscan_pkg::KIND_ASSIGN :
			                     (pend_q == tscan_pkg::P_LESS)  ? tscan_pkg::KIND_LESSEQ :
			                                                      tscan_pkg::KIND_GREATEREQ;
			cnt    = 2'd1;
			pend_d = tscan_pkg::P_NONE;
			plen_d = 16'd0;
			col_d  = col_inc;
		end else begin
			pend_d = tscan_pkg::P_NONE;
			kw_d   = tscan_pkg::KW_ALL;
			acc_d  = '0;
			ovf_d  = 1'b0;
			plen_d = 16'd0;
			if (src_byte == 8'h00) begin
				new_tok.token_kind   = tscan_pkg::KIND_EOF;
				new_tok.token_length = 16'd0;
				has_new              = 1'b1;
				ended_d              = 1'b1;
			end else if (src_byte == 8'h0A) begin
				line_d = (line_q == tscan_pkg::LINE_MAX) ? line_q : line_q + 24'd1;
				col_d  = 16'd1;
			end else if (blank) begin
				col_d = col_inc;
			end else if (alpha) begin
				kw_d    = tscan_pkg::kw_filter(tscan_pkg::KW_ALL, 16'd0, src_byte);
				pend_d  = tscan_pkg::P_WORD;
				plen_d  = 16'd1;
				start_d = col_q;
				col_d   = col_inc;
			end else if (digit) begin
				acc_d   = 63'(src_byte[3:0]);
				pend_d  = tscan_pkg::P_NUM;
				plen_d  = 16'd1;
				start_d = col_q;
				col_d   = col_inc;
			end else if (src_byte == ":" || src_byte == "<" || src_byte == ">") begin
				pend_d  = (src_byte == ":") ? tscan_pkg::P_COLON :
				          (src_byte == "<") ? tscan_pkg::P_LESS : tscan_pkg::P_GREATER;
				plen_d  = 16'd1;
				start_d = col_q;
				col_d   = col_inc;
			end else begin
				new_tok.token_kind   = tscan_pkg::single_kind(src_byte);
				new_tok.token_length = 16'd1;
				new_tok.odd_byte     = (new_tok.token_kind == tscan_pkg::KIND_UNKNOWN) ?
				                       src_byte : 8'd0;
				has_new              = 1'b1;
				col_d                = col_inc;
			end
			first  = has_flush ? flush_tok : new_tok;
			second = new_tok;
			cnt    = {1'b0, has_flush} + {1'b0, has_new};
		end

		if (cnt == 2'd2)
			second.run_last = 1'b1;
		else if (cnt == 2'd1)
			first.run_last = 1'b1;

		push.cnt    = fire ? cnt : 2'd0;
		push.first  = first;
		push.second = second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= tscan_pkg::P_NONE;
			kw_q    <= tscan_pkg::KW_ALL;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			plen_q  <= '0;
			line_q  <= 24'd1;
			col_q   <= 16'd1;
			start_q <= 16'd1;
			ended_q <= 1'b0;
		end else if (fire) begin
			pend_q  <= pend_d;
			kw_q    <= kw_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			plen_q  <= plen_d;
			line_q  <= line_d;
			col_q   <= col_d;
			start_q <= start_d;
			ended_q <= ended_d;
		end
	end

	assign ended = ended_q;

endmodule

`default_nettype wire

FILE: rtl/tscan_fifo.sv
// result queue, up to two words in and one word out per cycle
`default_nettype none

module tscan_fifo #(
	parameter int DEPTH = tscan_pkg::FIFO_DEPTH_DEF,
	localparam int PW = $clog2(DEPTH),
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tscan_pkg::push_t  push,
	input  wire logic              pop,
	output tscan_pkg::token_t      head,
	output logic                   head_valid,
	output logic [LW-1:0]          level
);

	tscan_pkg::token_t mem_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q, wr_p1, wr_p2;
	logic [LW-1:0]     level_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_p1 = wrap_inc(wr_q);
	assign wr_p2 = wrap_inc(wr_p1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.first;
		if (push.cnt == 2'd2)
			mem_q[wr_p1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			case (push.cnt)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop)
				rd_q <= wrap_inc(rd_q);
			level_q <= level_q + LW'(push.cnt) - LW'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign head_valid = level_q != '0;
	assign level      = level_q;

endmodule

`default_nettype wire

FILE: rtl/pl0_token_scanner.sv
// token scanner top level: byte input stage, scanner core and result queue
//
// src carries one source byte per word; byte 0 marks the end of the text.
// tok carries one token per word: kind, start line and column, length,
// number value and overflow flag, offending byte of an unknown token, and
// run_last, set on the last token caused by one source byte.
// a byte is taken into the input register; when the queue has room, the core
// updates its state and writes zero, one or two tokens into the result queue.
// a token passes from the input register through the core into the result
// queue, whose head drives tok.
// throughput: one byte per cycle as long as bytes produce at most one token
// each and tok is taken; a byte that produces two tokens slows the output
// side, since the queue has a single read port.
// the core only advances when the queue has room for two words, so a stalled
// tok lets the queue fill past FIFO_DEPTH - 2 words, then the input register holds its
// byte and src.ready drops.
// after the end byte every further byte is answered with one end token.
// reset clears the queue and puts the scanner at line 1, column 1.
`default_nettype none

module pl0_token_scanner #(
	parameter int FIFO_DEPTH = tscan_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tscan_byte_if.sink    src,
	tscan_token_if.source tok
);

	localparam int LW = $clog2(FIFO_DEPTH + 1);

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	logic              ended;
	logic              pop;
	logic [LW-1:0]     level;
	tscan_pkg::push_t  push;
	tscan_pkg::token_t head;
	logic              head_valid;

	// work on the held byte only when both result words can be stored
	assign fire      = valid_s1 && (level <= LW'(FIFO_DEPTH - 2));
	assign src.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.valid && src.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready)
			byte_s1 <= src.source_byte;
	end

	// scanner state and token decision
	tscan_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.src_byte (byte_s1),
		.push     (push),
		.ended    (ended)
	);

	// result queue decouples tok stalls from the scanner
	tscan_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.level      (level)
	);

	assign pop                 = tok.valid && tok.ready;
	assign tok.valid           = head_valid;
	assign tok.token_kind      = head.token_kind;
	assign tok.token_line      = head.token_line;
	assign tok.token_column    = head.token_column;
	assign tok.token_length    = head.token_length;
	assign tok.number_value    = head.number_value;
	assign tok.number_overflow = head.number_overflow;
	assign tok.odd_byte        = head.odd_byte;
	assign tok.run_last        = head.run_last;

	// a byte never yields more than two tokens
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3)
		else $error("more than two tokens from one byte");

	// only the second of two tokens closes the byte
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.second.run_last && !push.first.run_last)
		else $error("run_last misplaced on token pair");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd1 |-> push.first.run_last)
		else $error("run_last missing on single token");

	// queue never overfills
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LW'(FIFO_DEPTH))
		else $error("result queue overflow");

	// end of input stays until reset
	a_ended: assert property (@(posedge clk) disable iff (!arst_n)
		ended |=> ended)
		else $error("end of input flag dropped");

endmodule

`default_nettype wire

FILE: tb/tscan_token_checker.sv
// token checker: predicts scanner tokens from accepted bytes and compares the token channel
module tscan_token_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tscan_byte_if     src,
	tscan_token_if    tok,
	output int        mismatches,
	output int        tokens_due
);

	localparam int REPORT_LIMIT = 10;
	localparam int WORD_KEEP    = 9;

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	// keyword spellings in kind order
	string kw_words [tscan_pkg::KW_COUNT] = '{"const", "var", "procedure", "call", "begin",
		"end", "if", "then", "while", "do", "odd"};

	tscan_pkg::token_t token_fifo [$];
	tscan_pkg::pend_t  held;
	logic [7:0]        word_chars [WORD_KEEP];
	logic [62:0]       num_acc;
	logic              num_ovf;
	logic [15:0]       held_len;
	logic [15:0]       held_col;
	logic [23:0]       cur_line;
	logic [15:0]       cur_col;
	logic              text_done;

	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (&v) ? v : v + 16'd1;
	endfunction

	function automatic tscan_pkg::token_t build_token(input logic [5:0] kind,
			input logic [15:0] col, input logic [15:0] len, input logic [62:0] value,
			input logic ovf, input logic [7:0] odd);
		tscan_pkg::token_t t;
		t.token_kind      = kind;
		t.token_line      = cur_line;
		t.token_column    = col;
		t.token_length    = len;
		t.number_value    = value;
		t.number_overflow = ovf;
		t.odd_byte        = odd;
		t.run_last        = 1'b0;
		return t;
	endfunction

	// whole-word compare against each keyword, case folded
	function automatic logic [5:0] word_kind();
		int         i;
		int         j;
		logic       hit;
		logic [5:0] kind;
		kind = tscan_pkg::KIND_IDENT;
		for (i = 0; i < tscan_pkg::KW_COUNT; i++) begin
			if (held_len == 16'(kw_words[i].len())) begin
				hit = 1'b1;
				for (j = 0; j < kw_words[i].len(); j++)
					if ((word_chars[j] | 8'h20) != kw_words[i][j])
						hit = 1'b0;
				if (hit)
					kind = tscan_pkg::KIND_KW_FIRST + 6'(i);
			end
		end
		return kind;
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		case (c)
			".":     return tscan_pkg::KIND_PERIOD;
			",":     return tscan_pkg::KIND_COMMA;
			";":     return tscan_pkg::KIND_SEMI;
			"?":     return tscan_pkg::KIND_QUERY;
			"!":     return tscan_pkg::KIND_BANG;
			"=":     return tscan_pkg::KIND_EQUAL;
			"#":     return tscan_pkg::KIND_HASH;
			"+":     return tscan_pkg::KIND_PLUS;
			"-":     return tscan_pkg::KIND_MINUS;
			"*":     return tscan_pkg::KIND_STAR;
			"/":     return tscan_pkg::KIND_SLASH;
			"(":     return tscan_pkg::KIND_LPAREN;
			")":     return tscan_pkg::KIND_RPAREN;
			default: return tscan_pkg::KIND_UNKNOWN;
		endcase
	endfunction

	function automatic tscan_pkg::token_t held_token();
		case (held)
			tscan_pkg::P_WORD:
				return build_token(word_kind(), held_col, held_len, '0, 1'b0, 8'd0);
			tscan_pkg::P_NUM:
				return build_token(tscan_pkg::KIND_NUMBER, held_col, held_len, num_acc,
					num_ovf, 8'd0);
			tscan_pkg::P_COLON:
				return build_token(tscan_pkg::KIND_UNKNOWN, held_col, 16'd1, '0, 1'b0, ":");
			tscan_pkg::P_LESS:
				return build_token(tscan_pkg::KIND_LESS, held_col, 16'd1, '0, 1'b0, 8'd0);
			default:
				return build_token(tscan_pkg::KIND_GREATER, held_col, 16'd1, '0, 1'b0, 8'd0);
		endcase
	endfunction

	task automatic add_digit(input logic [3:0] d);
		logic [66:0] wide;
		wide = 67'(num_acc) * 67'd10 + 67'(d);
		if (num_ovf || wide > 67'(tscan_pkg::NUM_MAX)) begin
			num_ovf = 1'b1;
			num_acc = tscan_pkg::NUM_MAX;
		end else begin
			num_acc = wide[62:0];
		end
	endtask

	task automatic open_token(input tscan_pkg::pend_t cls);
		held     = cls;
		held_len = 16'd1;
		held_col = cur_col;
		cur_col  = inc_sat(cur_col);
	endtask

	task automatic scan_byte(input logic [7:0] c);
		tscan_pkg::token_t out [2];
		int     n;
		int     i;
		logic   is_alpha;
		logic   is_digit;
		logic [5:0] kind;
		n        = 0;
		is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
		is_digit = c >= "0" && c <= "9";
		if (text_done) begin
			out[0] = build_token(tscan_pkg::KIND_EOF, cur_col, 16'd0, '0, 1'b0, 8'd0);
			n      = 1;
		end else if (held == tscan_pkg::P_WORD && (is_alpha || is_digit)) begin
			if (held_len < WORD_KEEP)
				word_chars[held_len[3:0]] = c;
			held_len = inc_sat(held_len);
			cur_col  = inc_sat(cur_col);
		end else if (held == tscan_pkg::P_NUM && is_digit) begin
			add_digit(4'(c - "0"));
			held_len = inc_sat(held_len);
			cur_col  = inc_sat(cur_col);
		end else if ((held == tscan_pkg::P_COLON || held == tscan_pkg::P_LESS ||
		              held == tscan_pkg::P_GREATER) && c == "=") begin
			kind = (held == tscan_pkg::P_COLON) ? tscan_pkg::KIND_ASSIGN :
			       (held == tscan_pkg::P_LESS)  ? tscan_pkg::KIND_LESSEQ :
			                                      tscan_pkg::KIND_GREATEREQ;
			out[0]   = build_token(kind, held_col, 16'd2, '0, 1'b0, 8'd0);
			n        = 1;
			held     = tscan_pkg::P_NONE;
			held_len = '0;
			cur_col  = inc_sat(cur_col);
		end else begin
			// whatever was pending ends here
			if (held != tscan_pkg::P_NONE) begin
				out[n]   = held_token();
				n++;
				held     = tscan_pkg::P_NONE;
				num_acc  = '0;
				num_ovf  = 1'b0;
				held_len = '0;
			end
			if (c == CH_END) begin
				out[n]    = build_token(tscan_pkg::KIND_EOF, cur_col, 16'd0, '0, 1'b0, 8'd0);
				n++;
				text_done = 1'b1;
			end else if (c == CH_NL) begin
				if (cur_line != tscan_pkg::LINE_MAX)
					cur_line++;
				cur_col = 16'd1;
			end else if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_FF ||
			             c == CH_VT) begin
				cur_col = inc_sat(cur_col);
			end else if (is_alpha) begin
				word_chars[0] = c;
				open_token(tscan_pkg::P_WORD);
			end else if (is_digit) begin
				num_acc = 63'(c - "0");
				num_ovf = 1'b0;
				open_token(tscan_pkg::P_NUM);
			end else if (c == ":") begin
				open_token(tscan_pkg::P_COLON);
			end else if (c == "<") begin
				open_token(tscan_pkg::P_LESS);
			end else if (c == ">") begin
				open_token(tscan_pkg::P_GREATER);
			end else begin
				kind   = punct_kind(c);
				out[n] = build_token(kind, cur_col, 16'd1, '0, 1'b0,
					(kind == tscan_pkg::KIND_UNKNOWN) ? c : 8'd0);
				n++;
				cur_col = inc_sat(cur_col);
			end
		end
		if (n > 0)
			out[n-1].run_last = 1'b1;
		for (i = 0; i < n; i++)
			token_fifo.push_back(out[i]);
	endtask

	task automatic show_token(input string tag, input tscan_pkg::token_t t);
		$display("  %s kind %0d line %0d column %0d length %0d value %0d ovf %0b odd %02h last %0b",
			tag, t.token_kind, t.token_line, t.token_column, t.token_length,
			t.number_value, t.number_overflow, t.odd_byte, t.run_last);
	endtask

	task automatic check_token();
		tscan_pkg::token_t got;
		tscan_pkg::token_t want;
		logic   bad;
		got.token_kind      = tok.token_kind;
		got.token_line      = tok.token_line;
		got.token_column    = tok.token_column;
		got.token_length    = tok.token_length;
		got.number_value    = tok.number_value;
		got.number_overflow = tok.number_overflow;
		got.odd_byte        = tok.odd_byte;
		got.run_last        = tok.run_last;
		if (token_fifo.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("token with none expected at %0t", $realtime);
				show_token("actual  ", got);
			end
		end else begin
			want = token_fifo.pop_front();
			bad  = (got.token_kind !== want.token_kind) ||
				(got.token_line !== want.token_line) ||
				(got.token_column !== want.token_column) ||
				(got.token_length !== want.token_length) ||
				(got.number_value !== want.number_value) ||
				(got.number_overflow !== want.number_overflow) ||
				(got.odd_byte !== want.odd_byte) ||
				(got.run_last !== want.run_last);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("token mismatch at %0t", $realtime);
					show_token("expected", want);
					show_token("actual  ", got);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_fifo.delete();
			held       = tscan_pkg::P_NONE;
			num_acc    = '0;
			num_ovf    = 1'b0;
			held_len   = '0;
			held_col   = 16'd1;
			cur_line   = 24'd1;
			cur_col    = 16'd1;
			text_done  = 1'b0;
			mismatches = 0;
			tokens_due <= 0;
		end else begin
			if (src.valid && src.ready)
				scan_byte(src.source_byte);
			if (tok.valid && tok.ready)
				check_token();
			tokens_due <= token_fifo.size();
		end
	end

endmodule

FILE: tb/tb_pl0_token_scanner.sv
// token scanner testbench top: clock, reset, byte stimulus, token sink and verdict
module tb_pl0_token_scanner;

	localparam int RESET_CYCLES = 12;
	localparam int STALL_LIMIT  = 5000;   // cycles with no word moving on either side
	localparam int LONG_HOLD    = 400;    // token side held off, long enough to back up src
	localparam int TAIL_CYCLES  = 20;
	localparam int PHASE_BYTES  = 400;
	localparam int LONG_WORD    = 24;     // identifier well past any keyword length

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	logic clk;
	logic arst_n;
	logic hold_req;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   quiet_cycles;
	int   bytes_sent;
	int   mismatches;
	int   tokens_due;

	// stimulus vocabulary
	string kw_words [tscan_pkg::KW_COUNT] = '{"const", "var", "procedure", "call", "begin",
		"end", "if", "then", "while", "do", "odd"};
	string op_texts [6] = '{":=", "<=", ">=", "<", ">", ":"};
	// numbers around the 63-bit limit, plus leading zeros
	string num_limits [5] = '{"9223372036854775807", "9223372036854775808",
		"922337203685477580", "0000000000000000000009", "18446744073709551616"};
	string punct_text = ".,;?!=#+-*/()";
	logic [7:0] gap_bytes [6] = '{CH_SP, CH_TAB, CH_CR, CH_FF, CH_VT, CH_NL};

	tscan_byte_if  src ();
	tscan_token_if tok ();

	pl0_token_scanner u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.tok    (tok)
	);

	tscan_token_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.tok        (tok),
		.mismatches (mismatches),
		.tokens_due (tokens_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (src.valid && src.ready) || (tok.valid && tok.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_pl0_token_scanner failed");
			$finish;
		end
	end

	// token sink: random ready, or one long hold-off on request
	initial begin
		tok.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  <= 1'b0;
				tok.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			tok.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// offer one byte, with random idle cycles in front, and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			src.valid <= 1'b0;
			@(posedge clk);
		end
		src.valid       <= 1'b1;
		src.source_byte <= b;
		@(posedge clk);
		while (!src.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// letter or underscore for a word start, any word character otherwise
	function automatic logic [7:0] word_char(input bit lead);
		int r;
		r = lead ? $urandom_range(52) : $urandom_range(62);
		if (r < 26)
			return 8'(r) + "a";
		else if (r < 52)
			return 8'(r - 26) + "A";
		else if (r == 52)
			return "_";
		else
			return 8'(r - 53) + "0";
	endfunction

	// one random lexeme, mostly well formed, some noise, then maybe a separator
	task automatic send_token();
		int         pick;
		int         len;
		int         i;
		string      w;
		logic [7:0] ch;
		pick = $urandom_range(99);
		if (pick < 14) begin
			// keyword in random case
			w = kw_words[$urandom_range(tscan_pkg::KW_COUNT-1)];
			for (i = 0; i < w.len(); i++) begin
				ch = w[i];
				if ($urandom_range(1))
					ch = ch - 8'd32;
				send_byte(ch);
			end
		end else if (pick < 28) begin
			len = $urandom_range(12, 1);
			send_byte(word_char(1'b1));
			for (i = 1; i < len; i++)
				send_byte(word_char(1'b0));
		end else if (pick < 42) begin
			if ($urandom_range(9) == 0) begin
				send_text(num_limits[$urandom_range(4)]);
			end else begin
				len = ($urandom_range(3) == 0) ? $urandom_range(21, 15) : $urandom_range(6, 1);
				for (i = 0; i < len; i++)
					send_byte(8'($urandom_range(9)) + "0");
			end
		end else if (pick < 56) begin
			send_text(op_texts[$urandom_range(5)]);
		end else if (pick < 70) begin
			send_byte(punct_text[$urandom_range(punct_text.len() - 1)]);
		end else if (pick < 82) begin
			send_byte(gap_bytes[$urandom_range(5)]);
		end else begin
			// noise, never the end marker
			send_byte(8'($urandom_range(255, 1)));
		end
		pick = $urandom_range(9);
		if (pick < 5)
			send_byte(CH_SP);
		else if (pick == 5)
			send_byte(CH_NL);
	endtask

	task automatic scan_burst(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_token();
	endtask

	// stop offering and wait until every predicted token has come out
	task automatic drain_tokens();
		src.valid <= 1'b0;
		do
			@(posedge clk);
		while (tokens_due != 0);
	endtask

	initial begin
		arst_n          <= 1'b0;
		hold_req        <= 1'b0;
		src.valid       <= 1'b0;
		src.source_byte <= '0;
		src_idle_pct    <= 30;
		sink_idle_pct   <= 52;
		bytes_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lone colons, the three two-byte operators, a < and > cut short,
		// a colon flushed by a byte that is itself unknown (two tokens from one byte),
		// the top byte value and 8'h01, every skipped blank but the space, and a newline
		send_text(":a:=<=>=<9>::");
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(CH_TAB);
		send_byte(CH_CR);
		send_byte(CH_FF);
		send_byte(CH_VT);
		send_byte(CH_NL);
		send_text("?!_;");

		// sender idles 30 in 100, sink 52 in 100
		scan_burst(PHASE_BYTES);
		drain_tokens();

		// swapped, with one long hold-off on the token side in the middle
		src_idle_pct  <= 52;
		sink_idle_pct <= 30;
		scan_burst(PHASE_BYTES / 2);
		hold_req <= 1'b1;
		scan_burst(PHASE_BYTES / 2);

		// full rate on both sides
		src_idle_pct  <= 0;
		sink_idle_pct <= 0;
		scan_burst(PHASE_BYTES);

		// one long identifier, then tokens past it
		send_byte(CH_NL);
		send_byte(word_char(1'b1));
		repeat (LONG_WORD - 1) send_byte(word_char(1'b0));
		send_text(" 12 := ab <");
		send_byte(CH_NL);
		send_text("end.");

		// end of text, then bytes that only get end tokens back
		send_byte(CH_END);
		send_byte(CH_END);
		send_byte(8'hFF);
		send_text("x:=9");
		drain_tokens();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && tokens_due == 0)
			$display("tb_pl0_token_scanner passed");
		else
			$display("tb_pl0_token_scanner failed");
		$finish;
	end

endmodule
